[rtl/core/cubtrj_pkg.sv]
// Shared types and constants for the cubic trajectory generator.
`timescale 1ns / 1ps
package cubtrj_pkg;

    localparam int POS_W  = 22;
    localparam int DUR_W  = 16;
    localparam int INV_W  = 32;
    localparam int COEF_W = 48;
    localparam int MB_W   = 33;
    localparam int PROD_W = COEF_W + MB_W;
    localparam int ACC_W  = 50;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MB_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MB_W - 1);

    localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(2097151);
    localparam logic signed [ACC_W-1:0] POS_MIN = -ACC_W'(2097152);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_K2,
        ST_MUL_K3,
        ST_LOAD_WR,
        ST_EV_U,
        ST_EV_U2,
        ST_EV_U3,
        ST_EV_VT,
        ST_EV_C2,
        ST_EV_C3,
        ST_OUT
    } t_state;

endpackage

[rtl/core/cubic_trajectory_generator.sv]
// Cubic trajectory generator: segment load and per-leg position evaluation.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall | req_type, leg, axis, pos, vel, T, t
//  out     | output    | o_out_valid/i_out_stall | pos_x, pos_y, pos_z
//
// One transaction at a time through a bit-serial shift-add multiplier (one multiplier bit
// per cycle) and a restoring divider (one quotient bit per cycle). Load: a divide, two
// products, then a segment write. Evaluate: three time-power products, then three per
// axis, then the result; the time-power products are skipped when the step reaches the segment end.
// Reset clears state and loads unit segments; a stalled result holds until taken.
`timescale 1ns / 1ps
module cubic_trajectory_generator
    import cubtrj_pkg::*;
#(
    parameter int NUM_LEGS = 2,
    parameter int NUM_AXES = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_req_type,
    input  logic                    i_leg_sel,
    input  logic [1:0]              i_axis_sel,
    input  logic signed [POS_W-1:0] i_start_pos,
    input  logic signed [POS_W-1:0] i_end_pos,
    input  logic signed [POS_W-1:0] i_start_vel,
    input  logic signed [POS_W-1:0] i_end_vel,
    input  logic [DUR_W-1:0]        i_duration,
    input  logic [DUR_W-1:0]        i_step_index,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [POS_W-1:0] o_pos_z
);

    localparam int LEG_W = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
    localparam int AX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic [1:0] AX_LAST = 2'(NUM_AXES - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // segment store
    logic signed [POS_W-1:0]  r_bp  [0:NUM_LEGS-1][0:NUM_AXES-1];
    logic signed [POS_W-1:0]  r_bv  [0:NUM_LEGS-1][0:NUM_AXES-1];
    logic signed [COEF_W-1:0] r_c2  [0:NUM_LEGS-1][0:NUM_AXES-1];
    logic signed [COEF_W-1:0] r_c3  [0:NUM_LEGS-1][0:NUM_AXES-1];
    logic [DUR_W-1:0]         r_seg [0:NUM_LEGS-1];
    logic [INV_W-1:0]         r_inv [0:NUM_LEGS-1];

    // transaction payload
    logic                     r_leg;
    logic [1:0]               r_axis, r_ax;
    logic signed [POS_W-1:0]  r_p0, r_pf, r_v0, r_vf;
    logic [DUR_W-1:0]         r_dur, r_t;
    logic [DUR_W:0]           r_rem;
    logic [MB_W-1:0]          r_quot;
    logic signed [COEF_W-1:0] r_m2, r_m3;
    logic [INV_W-1:0]         r_u;
    logic [MB_W-1:0]          r_u2, r_u3;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [POS_W-1:0]  r_pos [0:2];
    logic [PROD_W-1:0]        r_prod, n_prod;

    logic [LEG_W-1:0] legi;
    logic [AX_W-1:0]  axi;
    logic             in_acc, leg_ok, axis_ok;
    logic [DUR_W-1:0] in_t, dur_fix;

    logic [COEF_W-1:0] m_a;
    logic [MB_W-1:0]   m_b;
    logic [COEF_W:0]   m_sum;
    logic              m_neg, m_done;

    logic [DUR_W:0]           rem_sh;
    logic                     q_bit;
    logic signed [23:0]       k2;
    logic signed [22:0]       k3;
    logic signed [COEF_W-1:0] d48, c2_new, c3_new, cur_c;
    logic signed [ACC_W-1:0]  term, sum;
    logic signed [POS_W-1:0]  sat;
    logic                     wr_seg, wr_pos, clr_pos;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign leg_ok  = int'(i_leg_sel) < NUM_LEGS;
    assign axis_ok = int'(i_axis_sel) < NUM_AXES;
    assign in_t    = r_seg[LEG_W'(i_leg_sel)];
    assign dur_fix = (i_duration == '0) ? DUR_W'(1) : i_duration;
    assign legi    = LEG_W'(r_leg);
    assign axi     = AX_W'(r_ax);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_pos_z     = r_pos[2];

    // load-side arithmetic
    assign k2     = (24'(r_v0) <<< 1) + 24'(r_vf);
    assign k3     = 23'(r_v0) + 23'(r_vf);
    assign d48    = COEF_W'(r_pf) - COEF_W'(r_p0);
    assign c2_new = (d48 <<< 1) + d48 - r_m2;
    assign c3_new = r_m3 - (d48 <<< 1);

    // restoring divide of 2^32 by the duration
    assign rem_sh = {r_rem[DUR_W-1:0], (r_cnt == '0)};
    assign q_bit  = (rem_sh >= {1'b0, r_dur});

    assign cur_c = (r_state == ST_EV_C2) ? r_c2[legi][axi] : r_c3[legi][axi];

    // multiplier operands per state; magnitudes are zero-extended
    always_comb begin
        m_a   = '0;
        m_b   = '0;
        m_neg = 1'b0;
        unique case (r_state)
            ST_MUL_K2: begin
                m_neg = k2[23];
                m_a   = COEF_W'($unsigned(k2[23] ? 24'(-k2) : 24'(k2)));
                m_b   = MB_W'(r_dur);
            end
            ST_MUL_K3: begin
                m_neg = k3[22];
                m_a   = COEF_W'($unsigned(k3[22] ? 23'(-k3) : 23'(k3)));
                m_b   = MB_W'(r_dur);
            end
            ST_EV_U: begin
                m_a = COEF_W'(r_inv[legi]);
                m_b = MB_W'(r_t);
            end
            ST_EV_U2: begin
                m_a = COEF_W'(r_u);
                m_b = MB_W'(r_u);
            end
            ST_EV_U3: begin
                m_a = COEF_W'(r_u2);
                m_b = MB_W'(r_u);
            end
            ST_EV_VT: begin
                m_neg = r_bv[legi][axi][POS_W-1];
                m_a   = COEF_W'($unsigned(m_neg ? POS_W'(-r_bv[legi][axi])
                                                : POS_W'(r_bv[legi][axi])));
                m_b   = MB_W'(r_t);
            end
            ST_EV_C2, ST_EV_C3: begin
                m_neg = cur_c[COEF_W-1];
                m_a   = m_neg ? COEF_W'(-cur_c) : COEF_W'(cur_c);
                m_b   = (r_state == ST_EV_C2) ? r_u2 : r_u3;
            end
            default: begin
                m_a = '0;
            end
        endcase
    end

    assign m_sum  = {1'b0, r_prod[PROD_W-1:MB_W]} + (r_prod[0] ? {1'b0, m_a} : '0);
    assign m_done = (r_cnt == MUL_LAST);

    always_comb begin
        if (r_cnt == '0) begin
            n_prod = {{COEF_W{1'b0}}, m_b};
        end else begin
            n_prod = {m_sum, r_prod[MB_W-1:1]};
        end
    end

    // signed product term for the accumulator, truncated toward zero
    always_comb begin
        term = (r_state == ST_EV_VT) ? ACC_W'(n_prod[37:0])
                                     : ACC_W'(n_prod[PROD_W-1:INV_W]);
        if (m_neg) begin
            term = -term;
        end
        sum = r_acc + term;
        priority if (sum > POS_MAX) begin
            sat = POS_W'(POS_MAX);
        end else if (sum < POS_MIN) begin
            sat = POS_W'(POS_MIN);
        end else begin
            sat = POS_W'(sum);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        wr_seg  = 1'b0;
        wr_pos  = 1'b0;
        clr_pos = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (in_acc) begin
                    if (i_req_type == REQ_LOAD) begin
                        if (leg_ok && axis_ok) begin
                            n_state = ST_DIV;
                        end
                    end else begin
                        clr_pos = 1'b1;
                        priority if (!leg_ok) begin
                            n_state = ST_OUT;
                        end else if (i_step_index >= in_t) begin
                            n_state = ST_EV_VT;
                        end else begin
                            n_state = ST_EV_U;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_MUL_K2;
                end
            end
            ST_LOAD_WR: begin
                wr_seg  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_cnt = r_cnt + 1'b1;
                if (m_done) begin
                    n_cnt = '0;
                    unique case (r_state)
                        ST_MUL_K2: n_state = ST_MUL_K3;
                        ST_MUL_K3: n_state = ST_LOAD_WR;
                        ST_EV_U:   n_state = ST_EV_U2;
                        ST_EV_U2:  n_state = ST_EV_U3;
                        ST_EV_U3:  n_state = ST_EV_VT;
                        ST_EV_VT:  n_state = ST_EV_C2;
                        ST_EV_C2:  n_state = ST_EV_C3;
                        ST_EV_C3: begin
                            wr_pos  = 1'b1;
                            n_state = (r_ax == AX_LAST) ? ST_OUT : ST_EV_VT;
                        end
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // control and segment store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            for (int l = 0; l < NUM_LEGS; l++) begin
                r_seg[l] <= DUR_W'(1);
                r_inv[l] <= '1;
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_bp[l][a] <= '0;
                    r_bv[l][a] <= '0;
                    r_c2[l][a] <= '0;
                    r_c3[l][a] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (wr_seg) begin
                r_bp[legi][AX_W'(r_axis)] <= r_p0;
                r_bv[legi][AX_W'(r_axis)] <= r_v0;
                r_c2[legi][AX_W'(r_axis)] <= c2_new;
                r_c3[legi][AX_W'(r_axis)] <= c3_new;
                r_seg[legi] <= r_dur;
                r_inv[legi] <= r_quot[INV_W] ? '1 : r_quot[INV_W-1:0];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (in_acc) begin
            r_leg  <= i_leg_sel;
            r_axis <= i_axis_sel;
            r_p0   <= i_start_pos;
            r_pf   <= i_end_pos;
            r_v0   <= i_start_vel;
            r_vf   <= i_end_vel;
            r_dur  <= dur_fix;
            r_rem  <= '0;
            r_quot <= '0;
            r_ax   <= '0;
            r_t    <= (i_step_index >= in_t) ? in_t : i_step_index;
            r_u2   <= MB_W'(64'd1 << INV_W);
            r_u3   <= MB_W'(64'd1 << INV_W);
        end
        if (clr_pos) begin
            for (int a = 0; a < 3; a++) begin
                r_pos[a] <= '0;
            end
        end
        if (r_state == ST_DIV) begin
            r_rem  <= q_bit ? (rem_sh - {1'b0, r_dur}) : rem_sh;
            r_quot <= {r_quot[MB_W-2:0], q_bit};
        end
        if (m_done) begin
            unique case (r_state)
                ST_MUL_K2: r_m2 <= m_neg ? -COEF_W'(n_prod[COEF_W-1:0])
                                         : COEF_W'(n_prod[COEF_W-1:0]);
                ST_MUL_K3: r_m3 <= m_neg ? -COEF_W'(n_prod[COEF_W-1:0])
                                         : COEF_W'(n_prod[COEF_W-1:0]);
                ST_EV_U:   r_u  <= n_prod[INV_W-1:0];
                ST_EV_U2:  r_u2 <= MB_W'(n_prod[2*INV_W-1:INV_W]);
                ST_EV_U3:  r_u3 <= MB_W'(n_prod[2*INV_W-1:INV_W]);
                ST_EV_VT:  r_acc <= ACC_W'(r_bp[legi][axi]) + term;
                ST_EV_C2:  r_acc <= sum;
                default:   r_acc <= r_acc;
            endcase
        end
        if (wr_pos) begin
            r_pos[r_ax] <= sat;
            r_ax        <= r_ax + 1'b1;
        end
    end

`ifndef SYNTH
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_LOAD) |=> !o_out_valid)
        else $error("load transaction produced a result");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MUL_LAST)
        else $error("step counter out of range");

    a_bad_leg_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_EVAL && !leg_ok) |=> o_out_valid)
        else $error("invalid leg evaluate did not return zero result");
`endif

endmodule

[tb/sv/tb_cubic_trajectory_generator.sv]
// Self-checking testbench for the cubic trajectory generator.
`timescale 1ns / 1ps
module tb_cubic_trajectory_generator;
    import cubtrj_pkg::*;

    typedef struct packed {
        logic                    req_type;
        logic                    leg_sel;
        logic [1:0]              axis_sel;
        logic signed [POS_W-1:0] start_pos;
        logic signed [POS_W-1:0] end_pos;
        logic signed [POS_W-1:0] start_vel;
        logic signed [POS_W-1:0] end_vel;
        logic [DUR_W-1:0]        duration;
        logic [DUR_W-1:0]        step_index;
    } t_request;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_position;

    localparam int  LEGS      = 2;
    localparam int  AXES      = 3;
    localparam int  CYCLE_CAP = 3000000;
    localparam logic [1:0] AXIS_BAD = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_req_type = REQ_LOAD;
    logic i_leg_sel = 1'b0;
    logic [1:0] i_axis_sel = '0;
    logic signed [POS_W-1:0] i_start_pos = '0, i_end_pos = '0;
    logic signed [POS_W-1:0] i_start_vel = '0, i_end_vel = '0;
    logic [DUR_W-1:0] i_duration = '0, i_step_index = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;

    cubic_trajectory_generator DUT (.*);

    always #10 i_clk = ~i_clk;

    // trajectory state mirrored from the load transactions
    longint seg_p0 [LEGS][AXES];
    longint seg_v0 [LEGS][AXES];
    longint seg_c2 [LEGS][AXES];
    longint seg_c3 [LEGS][AXES];
    longint seg_len [LEGS];
    longint seg_inv [LEGS];

    t_request  pending_reqs[$];
    t_position expected_positions[$];
    int  errors = 0;
    int  cycles = 0;
    bit  stim_done = 1'b0;
    bit  hold_sender = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;

    function automatic longint scale_q32(longint c, longint f);
        longint mag;
        longint r;
        mag = (c < 0) ? -c : c;
        r = ((mag >>> 16) * f + (((mag & 16'hFFFF) * f) >>> 16)) >>> 16;
        return (c < 0) ? -r : r;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(longint v);
        if (v > 2097151) v = 2097151;
        if (v < -2097152) v = -2097152;
        return v[POS_W-1:0];
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(1, 4);
    endfunction

    task automatic predict_trajectory(input t_request r);
        longint d, tt, t, u, u2, u3, s;
        logic [POS_W-1:0] res [AXES];
        if (r.req_type == REQ_LOAD) begin
            if (r.axis_sel == AXIS_BAD) return;
            tt = (r.duration == 0) ? 1 : r.duration;
            d = longint'(r.end_pos) - longint'(r.start_pos);
            seg_p0[r.leg_sel][r.axis_sel] = r.start_pos;
            seg_v0[r.leg_sel][r.axis_sel] = r.start_vel;
            seg_c2[r.leg_sel][r.axis_sel] = 3 * d - 2 * longint'(r.start_vel) * tt
                                            - longint'(r.end_vel) * tt;
            seg_c3[r.leg_sel][r.axis_sel] = -2 * d
                + (longint'(r.start_vel) + longint'(r.end_vel)) * tt;
            seg_len[r.leg_sel] = tt;
            seg_inv[r.leg_sel] = ((64'd1 << 32) / tt > 64'hFFFFFFFF) ? 64'hFFFFFFFF
                                 : (64'd1 << 32) / tt;
            return;
        end
        t = r.step_index;
        if (t >= seg_len[r.leg_sel]) begin
            t = seg_len[r.leg_sel];
            u2 = 64'd1 << 32;
            u3 = 64'd1 << 32;
        end else begin
            u = t * seg_inv[r.leg_sel];
            if (u > 64'hFFFFFFFF) u = 64'hFFFFFFFF;
            u2 = (u * u) >> 32;
            u3 = (u2 * u) >> 32;
        end
        for (int a = 0; a < AXES; a++) begin
            s = seg_p0[r.leg_sel][a] + seg_v0[r.leg_sel][a] * t
                + scale_q32(seg_c2[r.leg_sel][a], u2) + scale_q32(seg_c3[r.leg_sel][a], u3);
            res[a] = clamp_pos(s);
        end
        expected_positions.push_back('{res[0], res[1], res[2]});
    endtask

    function automatic logic [POS_W-1:0] random_pos();
        case ($urandom_range(0, 5))
            0: return 22'h1FFFFF;
            1: return 22'h200000;
            2: return POS_W'($urandom_range(0, 4000) - 2000);
            default: return POS_W'($urandom());
        endcase
    endfunction

    function automatic t_request make_load(bit leg, logic [1:0] axis, logic [DUR_W-1:0] dur);
        t_request r;
        r = '0;
        r.req_type = REQ_LOAD;
        r.leg_sel = leg;
        r.axis_sel = axis;
        r.start_pos = random_pos();
        r.end_pos = random_pos();
        r.start_vel = $urandom_range(0, 1) ? random_pos()
                                           : POS_W'($urandom_range(0, 200) - 100);
        r.end_vel = $urandom_range(0, 1) ? random_pos()
                                         : POS_W'($urandom_range(0, 200) - 100);
        r.duration = dur;
        r.step_index = DUR_W'($urandom());
        return r;
    endfunction

    function automatic t_request make_eval(bit leg, logic [DUR_W-1:0] step);
        t_request r;
        r = make_load(leg, 2'($urandom()), 0);
        r.req_type = REQ_EVAL;
        r.duration = DUR_W'($urandom());
        r.step_index = step;
        return r;
    endfunction

    function automatic logic [DUR_W-1:0] random_dur();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return DUR_W'($urandom_range(0, 1));
            2: return DUR_W'($urandom());
            default: return DUR_W'($urandom_range(2, 300));
        endcase
    endfunction

    initial begin
        logic [DUR_W-1:0] dur;
        bit leg;
        // directed: evaluate after reset, extremes, zero duration, bad axis, clamping
        pending_reqs.push_back(make_eval(0, 0));
        pending_reqs.push_back(make_eval(1, 16'hFFFF));
        for (int a = 0; a < AXES; a++) begin
            t_request r;
            r = make_load(0, 2'(a), 16'hFFFF);
            r.start_pos = 22'h200000; r.end_pos = 22'h1FFFFF;
            r.start_vel = 22'h1FFFFF; r.end_vel = 22'h200000;
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(make_eval(0, 0));
        pending_reqs.push_back(make_eval(0, 16'h7FFF));
        pending_reqs.push_back(make_eval(0, 16'hFFFE));
        pending_reqs.push_back(make_eval(0, 16'hFFFF));
        pending_reqs.push_back(make_load(1, 0, 0));
        pending_reqs.push_back(make_load(1, 1, 1));
        pending_reqs.push_back(make_load(1, AXIS_BAD, 7));
        pending_reqs.push_back(make_eval(1, 0));
        pending_reqs.push_back(make_eval(1, 1));
        pending_reqs.push_back(make_eval(1, 16'hFFFF));
        pending_reqs.push_back(make_load(1, 2, 10));
        for (int s = 0; s <= 11; s += 3) pending_reqs.push_back(make_eval(1, DUR_W'(s)));
        // random: mostly full three-axis segments then sweeps through them
        while (pending_reqs.size() < 660) begin
            leg = 1'($urandom());
            dur = random_dur();
            if ($urandom_range(0, 3) != 0) begin
                for (int a = 0; a < AXES; a++)
                    pending_reqs.push_back(make_load(leg, 2'(a), dur));
                repeat ($urandom_range(1, 5))
                    pending_reqs.push_back(make_eval(leg, DUR_W'($urandom_range(0, 2) == 0 ?
                        $urandom() : $urandom_range(0, dur + 1))));
            end else if ($urandom_range(0, 1) == 0) begin
                pending_reqs.push_back(make_load(leg, 2'($urandom()), random_dur()));
            end else begin
                pending_reqs.push_back(make_eval(leg, DUR_W'($urandom())));
            end
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
            // hold the stalled transaction
        end else begin
            if (i_in_valid) predict_trajectory({i_req_type, i_leg_sel, i_axis_sel, i_start_pos,
                i_end_pos, i_start_vel, i_end_vel, i_duration, i_step_index});
            if (hold_sender && !i_in_valid) begin
                if (expected_positions.size() == 0) hold_sender <= 1'b0;
            end else if (i_in_valid && pending_reqs.size() == 330 && !hold_sender) begin
                // drain the result queue before sending more
                hold_sender <= 1'b1;
                i_in_valid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_request r;
                r = pending_reqs.pop_front();
                {i_req_type, i_leg_sel, i_axis_sel, i_start_pos, i_end_pos, i_start_vel,
                 i_end_vel, i_duration, i_step_index} <= r;
                i_in_valid <= 1'b1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : random_gap();
            end else begin
                i_in_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_positions.size() == 0) begin
                    $error("result with no expectation: x=%0d y=%0d z=%0d",
                           o_pos_x, o_pos_y, o_pos_z);
                    errors++;
                end else begin
                    t_position e;
                    e = expected_positions.pop_front();
                    if (o_pos_x !== e.x) begin
                        $error("pos_x expected %0d actual %0d", e.x, o_pos_x); errors++;
                    end
                    if (o_pos_y !== e.y) begin
                        $error("pos_y expected %0d actual %0d", e.y, o_pos_y); errors++;
                    end
                    if (o_pos_z !== e.z) begin
                        $error("pos_z expected %0d actual %0d", e.z, o_pos_z); errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                recv_gap <= random_gap();
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        for (int l = 0; l < LEGS; l++) begin
            seg_len[l] = 1;
            seg_inv[l] = 64'hFFFFFFFF;
            for (int a = 0; a < AXES; a++) begin
                seg_p0[l][a] = 0; seg_v0[l][a] = 0; seg_c2[l][a] = 0; seg_c3[l][a] = 0;
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && expected_positions.size() == 0)) begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("Mismatches found");
                $finish;
            end
        end
        repeat (500) @(posedge i_clk);
        if (errors == 0 && expected_positions.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cubtrj_pkg.sv
rtl/core/cubic_trajectory_generator.sv
tb/sv/tb_cubic_trajectory_generator.sv
